FILE: design/rsfr_pkg.sv
// rsfr_pkg: shared types and constants of the serial frame receiver
// (request and response payloads, configuration set, engine result struct)
// no dependencies
`timescale 1ns / 1ps

package rsfr_pkg;

   localparam int FRAME_BYTES      = 32;
   localparam int ADDR_W           = $clog2(FRAME_BYTES);
   localparam int SUM_BYTES        = 30;
   localparam int NUM_CHANNELS_DEF = 14;
   localparam int CSR_IDX_W        = 2;

   localparam logic [7:0]  HDR_FIRST  = 8'h20;
   localparam logic [7:0]  HDR_SECOND = 8'h40;
   localparam logic [15:0] SUM_SEED   = 16'hFFFF;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DISARMED  = 2'd1;
   localparam logic [1:0] ST_OUT_RANGE = 2'd2;
   localparam logic [1:0] ST_NO_SIGNAL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DISARM  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd3;

   localparam logic [15:0] DISARM_RST  = 16'd1600;
   localparam logic [15:0] MIN_RST     = 16'd900;
   localparam logic [15:0] MAX_RST     = 16'd2100;
   localparam logic [15:0] TIMEOUT_RST = 16'd1000;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  channel_index;
      logic [15:0] channel_value;
      logic [1:0]  link_status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] disarm_threshold;
      logic [15:0] min_valid_value;
      logic [15:0] max_valid_value;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } put_type;

endpackage

FILE: design/rsfr_frame_mem.sv
// rsfr_frame_mem: 32 x 8 frame byte store, one write port, one registered read port
// depends on rsfr_pkg
`timescale 1ns / 1ps

module rsfr_frame_mem
   import rsfr_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [FRAME_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rsfr_frame_engine.sv
// rsfr_frame_engine: frame-end sequencer; one pass over the store for checksum
// and status, then, on a good checksum, one channel word at a time to the response slot
// depends on rsfr_pkg, reads the store through rsfr_frame_mem
`timescale 1ns / 1ps

module rsfr_frame_engine
   import rsfr_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cfg_type           cfg,
   input  logic              slot_free,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              busy,
   output put_type           put
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_EMIT_LO,
      S_EMIT_HI,
      S_EMIT_PUT
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              issued_ff;
   logic              dv_ff;
   logic [ADDR_W-1:0] daddr_ff;
   logic [15:0]       sum_ff;
   logic [7:0]        lo_ff;
   logic              oor_ff;
   logic              dis_ff;
   logic [3:0]        ch_ff;

   logic [15:0]       word;
   logic [ADDR_W-1:0] ch_lo_addr;
   logic              ch_last;
   logic [1:0]        status;
   logic              stick_word;

   assign word       = {rd_data, lo_ff};
   assign ch_lo_addr = ADDR_W'({ch_ff, 1'b0}) + ADDR_W'(2);
   assign ch_last    = (ch_ff == 4'(NUM_CHANNELS - 1));
   assign status     = dis_ff ? ST_DISARMED : (oor_ff ? ST_OUT_RANGE : ST_OK);
   // high bytes of channels 0 to 3
   assign stick_word = (daddr_ff == ADDR_W'(3)) || (daddr_ff == ADDR_W'(5)) ||
                       (daddr_ff == ADDR_W'(7)) || (daddr_ff == ADDR_W'(9));

   always_comb begin
      unique case (state_ff)
         S_SUM:     rd_addr = addr_ff;
         S_EMIT_LO: rd_addr = ch_lo_addr;
         S_EMIT_HI,
         S_EMIT_PUT: rd_addr = ch_lo_addr + ADDR_W'(1);
         default:   rd_addr = '0;
      endcase
   end

   assign busy                   = (state_ff != S_IDLE);
   assign put.valid              = (state_ff == S_EMIT_PUT) && slot_free;
   assign put.data.channel_index = ch_ff;
   assign put.data.channel_value = word;
   assign put.data.link_status   = status;
   assign put.data.last          = ch_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dv_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               dv_ff <= 1'b0;
               if (start) begin
                  addr_ff   <= '0;
                  issued_ff <= 1'b0;
                  sum_ff    <= SUM_SEED;
                  oor_ff    <= 1'b0;
                  dis_ff    <= 1'b0;
                  ch_ff     <= '0;
                  state_ff  <= S_SUM;
               end
            end
            S_SUM: begin
               // issue side: one read address per cycle
               dv_ff    <= !issued_ff;
               daddr_ff <= addr_ff;
               if (!issued_ff) begin
                  addr_ff <= addr_ff + ADDR_W'(1);
                  if (addr_ff == ADDR_W'(FRAME_BYTES - 1)) begin
                     issued_ff <= 1'b1;
                  end
               end
               // data side: shared subtract and compares on the returning byte
               if (dv_ff) begin
                  if (daddr_ff < ADDR_W'(SUM_BYTES)) begin
                     sum_ff <= sum_ff - {8'd0, rd_data};
                  end
                  if (!daddr_ff[0]) begin
                     lo_ff <= rd_data;
                  end
                  if (stick_word && (word <= cfg.min_valid_value ||
                                     word >= cfg.max_valid_value)) begin
                     oor_ff <= 1'b1;
                  end
                  if (daddr_ff == ADDR_W'(11)) begin
                     dis_ff <= (word <= cfg.disarm_threshold);
                  end
                  // the sweep is fully issued here, so dv_ff drops above
                  if (daddr_ff == ADDR_W'(FRAME_BYTES - 1)) begin
                     state_ff <= (sum_ff == word) ? S_EMIT_LO : S_IDLE;
                  end
               end
            end
            S_EMIT_LO: begin
               state_ff <= S_EMIT_HI;
            end
            S_EMIT_HI: begin
               lo_ff    <= rd_data;
               state_ff <= S_EMIT_PUT;
            end
            S_EMIT_PUT: begin
               if (slot_free) begin
                  if (ch_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ch_ff    <= ch_ff + 4'd1;
                     state_ff <= S_EMIT_LO;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (put.valid && put.data.last) |=> !busy)
      else $error("engine still busy after the last channel");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      (start && busy) |-> 1'b0)
      else $error("frame end while the engine is busy");

   a_sum_ends_at_checksum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && dv_ff && daddr_ff == ADDR_W'(FRAME_BYTES - 1))
      |-> issued_ff)
      else $error("checksum word seen before the sweep was issued");

endmodule

FILE: design/rc_serial_frame_receiver.sv
// rc_serial_frame_receiver: top level; header sync, frame byte capture,
// silence counter, control registers and the response register
// depends on rsfr_pkg, rsfr_frame_mem, rsfr_frame_engine
`timescale 1ns / 1ps

// channel   ports                          direction  carries
// request   req_valid req_stall req_data   in         byte or tick
// response  rsp_valid rsp_stall rsp_data   out        channel word or no-signal
// control   csr_wr_en csr_index csr_wdata  in         threshold and timeout writes
//
// a byte or tick is taken whenever req_stall is low; a request that finishes a frame
// keeps the block busy for the store sweep (one store read per cycle) and, on a good
// checksum, through EMIT_LO, EMIT_HI and EMIT_PUT per channel on the single read port
// reset is synchronous; the control registers return to their defaults
// a stalled response holds; a new request is taken while the response register is
// full unless the response side is stalling

module rc_serial_frame_receiver
   import rsfr_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   cfg_type           cfg_ff;
   logic [15:0]       timeout_ff;
   logic [ADDR_W-1:0] pos_ff;
   logic [15:0]       silence_ff;
   logic [15:0]       silence_in;
   logic              reported_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              req_take;
   logic              is_byte;
   logic              hdr_bad;
   logic              store_byte;
   logic              frame_start;
   logic              tick_emit;
   logic              slot_free;
   logic              eng_busy;
   put_type           eng_put;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   rsp_type           tick_rsp;

   assign req_stall = eng_busy || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign is_byte   = (req_data.op == OP_BYTE);
   assign hdr_bad   = ((pos_ff == ADDR_W'(0)) && (req_data.data_byte != HDR_FIRST)) ||
                      ((pos_ff == ADDR_W'(1)) && (req_data.data_byte != HDR_SECOND));
   assign store_byte  = req_take && is_byte && !hdr_bad;
   assign frame_start = store_byte && (pos_ff == ADDR_W'(FRAME_BYTES - 1));

   assign silence_in = (silence_ff == 16'hFFFF) ? silence_ff : silence_ff + 16'd1;
   assign tick_emit  = req_take && !is_byte && (silence_in >= timeout_ff) && !reported_ff;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign tick_rsp.channel_index = 4'd0;
   assign tick_rsp.channel_value = 16'd0;
   assign tick_rsp.link_status   = ST_NO_SIGNAL;
   assign tick_rsp.last          = 1'b1;

   rsfr_frame_mem u_mem (
      .clock   (clock),
      .wr_en   (store_byte),
      .wr_addr (pos_ff),
      .wr_data (req_data.data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsfr_frame_engine #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (frame_start),
      .cfg       (cfg_ff),
      .slot_free (slot_free),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .busy      (eng_busy),
      .put       (eng_put)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disarm_threshold <= DISARM_RST;
         cfg_ff.min_valid_value  <= MIN_RST;
         cfg_ff.max_valid_value  <= MAX_RST;
         timeout_ff              <= TIMEOUT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DISARM:  cfg_ff.disarm_threshold <= csr_wdata;
            CSR_MIN:     cfg_ff.min_valid_value  <= csr_wdata;
            CSR_MAX:     cfg_ff.max_valid_value  <= csr_wdata;
            CSR_TIMEOUT: timeout_ff              <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // header sync and silence counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         silence_ff  <= '0;
         reported_ff <= 1'b0;
      end else if (req_take) begin
         if (!is_byte) begin
            silence_ff <= silence_in;
            if (tick_emit) begin
               reported_ff <= 1'b1;
            end
         end else if (hdr_bad) begin
            pos_ff <= '0;
         end else if (frame_start) begin
            pos_ff      <= '0;
            silence_ff  <= '0;
            reported_ff <= 1'b0;
         end else begin
            pos_ff <= pos_ff + ADDR_W'(1);
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tick_emit) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= tick_rsp;
      end else if (eng_put.valid) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= eng_put.data;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      eng_busy |-> req_stall)
      else $error("request taken while the frame engine is busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(tick_emit || eng_put.valid))
      else $error("response register overwritten while stalled");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      frame_start |=> (pos_ff == '0 && silence_ff == '0 && !reported_ff))
      else $error("frame end did not clear position and silence state");

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(tick_emit && eng_put.valid))
      else $error("tick and frame engine loaded the response together");

endmodule

FILE: dv/tb_rc_serial_frame_receiver.sv
// tb_rc_serial_frame_receiver: self-checking bench for the serial frame receiver;
// a short stimulus table, then random frames, ticks and noise, checked by a predictor
// depends on rsfr_pkg and rc_serial_frame_receiver
`timescale 1ns / 1ps

module tb_rc_serial_frame_receiver;
   import rsfr_pkg::*;

   localparam int SETTLE_CYCLES = 120;
   localparam int SHOWN_ERRORS  = 10;

   localparam rsp_type NO_SIGNAL_RSP = '{4'd0, 16'd0, ST_NO_SIGNAL, 1'b1};

   typedef enum logic [2:0] {
      ROW_BYTE,
      ROW_TICK,
      ROW_FRAME,
      ROW_BAD_FRAME,
      ROW_CSR
   } row_kind;

   // arg_a: byte, csr index or stick value; arg_b: csr value or channel 4 value
   typedef struct packed {
      row_kind     kind;
      logic [15:0] arg_a;
      logic [15:0] arg_b;
      logic        typed;
      logic        no_sig;
   } plan_row;

   localparam plan_row PLAN [24] = '{
      '{ROW_TICK,      16'd0,            16'd0,     1'b1, 1'b0},
      '{ROW_BYTE,      16'h00,           16'd0,     1'b1, 1'b0},
      '{ROW_BYTE,      16'hFF,           16'd0,     1'b1, 1'b0},
      '{ROW_BYTE,      16'h20,           16'd0,     1'b1, 1'b0},
      '{ROW_BYTE,      16'h20,           16'd0,     1'b1, 1'b0},   // second header byte wrong
      '{ROW_BYTE,      16'h40,           16'd0,     1'b1, 1'b0},   // dropped, not a first header
      '{ROW_FRAME,     16'd901,          16'd1601,  1'b0, 1'b0},
      '{ROW_FRAME,     16'd900,          16'd2000,  1'b0, 1'b0},
      '{ROW_FRAME,     16'd2100,         16'd2000,  1'b0, 1'b0},
      '{ROW_FRAME,     16'd2099,         16'd1600,  1'b0, 1'b0},
      '{ROW_FRAME,     16'd0,            16'd0,     1'b0, 1'b0},
      '{ROW_FRAME,     16'd65535,        16'd65535, 1'b0, 1'b0},
      '{ROW_BAD_FRAME, 16'd1500,         16'd2000,  1'b1, 1'b0},
      '{ROW_CSR,       16'(CSR_TIMEOUT), 16'd1,     1'b0, 1'b0},
      '{ROW_TICK,      16'd0,            16'd0,     1'b1, 1'b1},
      '{ROW_TICK,      16'd0,            16'd0,     1'b1, 1'b0},   // reported once only
      '{ROW_FRAME,     16'd1500,         16'd2000,  1'b0, 1'b0},
      '{ROW_TICK,      16'd0,            16'd0,     1'b1, 1'b1},
      '{ROW_CSR,       16'(CSR_DISARM),  16'd0,     1'b0, 1'b0},
      '{ROW_CSR,       16'(CSR_MIN),     16'd0,     1'b0, 1'b0},
      '{ROW_CSR,       16'(CSR_MAX),     16'd65535, 1'b0, 1'b0},
      '{ROW_FRAME,     16'd0,            16'd1,     1'b0, 1'b0},
      '{ROW_FRAME,     16'd1,            16'd0,     1'b0, 1'b0},
      '{ROW_FRAME,     16'd65534,        16'd65535, 1'b0, 1'b0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   // predictor copy of the registers and the receiver state
   logic [15:0] thr_disarm = DISARM_RST;
   logic [15:0] lim_low    = MIN_RST;
   logic [15:0] lim_high   = MAX_RST;
   logic [15:0] tick_limit = TIMEOUT_RST;
   logic [7:0]  stored_bytes [FRAME_BYTES];
   logic [4:0]  fill_pos     = '0;
   logic [15:0] quiet_ticks  = '0;
   logic        lost_flagged = 1'b0;

   rsp_type     words_due [$];
   rsp_type     words_new [$];
   logic [15:0] chan_words [NUM_CHANNELS_DEF];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   bit settle_needed = 1'b0;

   rc_serial_frame_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [15:0] stored_word(input int lo);
      return {stored_bytes[lo + 1], stored_bytes[lo]};
   endfunction

   // advance the receiver by one request; results land in words_new
   function automatic void decode_request(input logic op, input logic [7:0] b);
      logic [15:0] sum;
      logic [15:0] w;
      logic [1:0]  status;
      int          i;
      if (op == OP_TICK) begin
         if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
         if (quiet_ticks >= tick_limit && !lost_flagged) begin
            lost_flagged = 1'b1;
            words_new.push_back(NO_SIGNAL_RSP);
         end
      end else if (fill_pos == 5'd0 && b != HDR_FIRST) begin
         fill_pos = 5'd0;
      end else if (fill_pos == 5'd1 && b != HDR_SECOND) begin
         fill_pos = 5'd0;
      end else begin
         stored_bytes[fill_pos] = b;
         if (fill_pos != 5'(FRAME_BYTES - 1)) begin
            fill_pos = fill_pos + 5'd1;
         end else begin
            fill_pos     = 5'd0;
            quiet_ticks  = 16'd0;
            lost_flagged = 1'b0;
            sum = SUM_SEED;
            for (i = 0; i < SUM_BYTES; i++) sum = sum - 16'(stored_bytes[i]);
            if (sum == stored_word(SUM_BYTES)) begin
               status = ST_OK;
               if (stored_word(10) <= thr_disarm) begin
                  status = ST_DISARMED;
               end else begin
                  for (i = 0; i < 4; i++) begin
                     w = stored_word(2 + 2 * i);
                     if (w <= lim_low || w >= lim_high) status = ST_OUT_RANGE;
                  end
               end
               for (i = 0; i < NUM_CHANNELS_DEF; i++)
                  words_new.push_back('{4'(i), stored_word(2 + 2 * i), status,
                                        i == NUM_CHANNELS_DEF - 1});
            end
         end
      end
   endfunction

   task automatic send_req(input logic op, input logic [7:0] b, input bit typed,
                           input bit no_sig);
      csr_wr_en <= 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op, b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_new.delete();
      decode_request(op, b);
      if (typed) begin
         if (no_sig) words_due.push_back(NO_SIGNAL_RSP);
      end else begin
         foreach (words_new[i]) words_due.push_back(words_new[i]);
      end
      settle_needed = 1'b1;
   endtask

   // registers change only with the block idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      req_valid <= 1'b0;
      if (settle_needed) begin
         while (words_due.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         settle_needed = 1'b0;
      end
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DISARM:  thr_disarm = val;
         CSR_MIN:     lim_low    = val;
         CSR_MAX:     lim_high   = val;
         CSR_TIMEOUT: tick_limit = val;
         default: ;
      endcase
   endtask

   // resync to position 0, then send the first upto bytes of a frame from chan_words
   task automatic send_frame(input bit corrupt, input bit typed, input bit stray,
                             input int upto);
      logic [7:0]  fb [FRAME_BYTES];
      logic [15:0] sum;
      int          k;
      while (fill_pos != 5'd0) send_req(OP_BYTE, 8'($urandom), 1'b0, 1'b0);
      fb[0] = HDR_FIRST;
      fb[1] = HDR_SECOND;
      for (k = 0; k < NUM_CHANNELS_DEF; k++) begin
         fb[2 + 2 * k] = chan_words[k][7:0];
         fb[3 + 2 * k] = chan_words[k][15:8];
      end
      sum = SUM_SEED;
      for (k = 0; k < SUM_BYTES; k++) sum = sum - 16'(fb[k]);
      fb[30] = sum[7:0];
      fb[31] = sum[15:8];
      if (corrupt) fb[30 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      for (k = 0; k < upto; k++) begin
         if (stray && $urandom_range(0, 99) < 4) send_req(OP_TICK, 8'($urandom), 1'b0, 1'b0);
         send_req(OP_BYTE, fb[k], typed, 1'b0);
      end
   endtask

   function automatic logic [15:0] pick_stick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75 && int'(lim_high) - int'(lim_low) >= 2)
         return 16'($urandom_range(int'(lim_low) + 1, int'(lim_high) - 1));
      else if (r < 80) return lim_low;
      else if (r < 84) return lim_low + 16'd1;
      else if (r < 88) return lim_high;
      else if (r < 92) return lim_high - 16'd1;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_arm();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80 && thr_disarm != 16'hFFFF)
         return 16'($urandom_range(int'(thr_disarm) + 1, 65535));
      else if (r < 87) return thr_disarm;
      else if (r < 94) return thr_disarm + 16'd1;
      return 16'($urandom);
   endfunction

   task automatic fill_channels(input logic [15:0] stick, input logic [15:0] arm,
                                input bit random_sticks);
      int k;
      for (k = 0; k < NUM_CHANNELS_DEF; k++) chan_words[k] = 16'($urandom);
      for (k = 0; k < 4; k++) chan_words[k] = random_sticks ? pick_stick() : stick;
      chan_words[4] = random_sticks ? pick_arm() : arm;
   endtask

   task automatic set_random_config();
      case ($urandom_range(0, 4))
         0: begin
            write_csr(CSR_DISARM, 16'd0);
            write_csr(CSR_MIN, 16'd0);
            write_csr(CSR_MAX, 16'hFFFF);
         end
         1: begin
            write_csr(CSR_DISARM, 16'hFFFF);
            write_csr(CSR_MIN, 16'hFFFF);
            write_csr(CSR_MAX, 16'd0);
         end
         default: begin
            write_csr(CSR_DISARM, 16'($urandom_range(1000, 2000)));
            write_csr(CSR_MIN, 16'($urandom_range(800, 1100)));
            write_csr(CSR_MAX, 16'($urandom_range(1900, 2200)));
         end
      endcase
      case ($urandom_range(0, 5))
         0: write_csr(CSR_TIMEOUT, 16'hFFFF);
         1: write_csr(CSR_TIMEOUT, 16'd1);
         2: write_csr(CSR_TIMEOUT, 16'($urandom_range(1, 65535)));
         default: write_csr(CSR_TIMEOUT, 16'($urandom_range(2, 16)));
      endcase
   endtask

   // mostly well-formed frames with random content, the rest broken frames and noise
   task automatic run_random(input int target);
      int done;
      int pick;
      int n;
      int k;
      done = 0;
      set_random_config();
      while (done < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) set_random_config();
         if (pick < 60) begin
            fill_channels(16'd0, 16'd0, 1'b1);
            send_frame(1'b0, 1'b0, 1'b1, FRAME_BYTES);
            done += FRAME_BYTES;
         end else if (pick < 70) begin
            fill_channels(16'd0, 16'd0, 1'b1);
            send_frame(1'b1, 1'b0, 1'b1, FRAME_BYTES);
            done += FRAME_BYTES;
         end else if (pick < 78) begin
            n = $urandom_range(1, FRAME_BYTES - 1);
            fill_channels(16'd0, 16'd0, 1'b1);
            send_frame(1'b0, 1'b0, 1'b1, n);
            done += n;
         end else if (pick < 90) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) send_req(OP_TICK, 8'($urandom), 1'b0, 1'b0);
            done += n;
         end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
               case ($urandom_range(0, 2))
                  0: send_req(OP_BYTE, HDR_FIRST, 1'b0, 1'b0);
                  1: send_req(OP_BYTE, HDR_SECOND, 1'b0, 1'b0);
                  default: send_req(OP_BYTE, 8'($urandom), 1'b0, 1'b0);
               endcase
            done += n;
         end
      end
   endtask

   // response side: random stall, compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
               $display("unexpected response: idx=%0d val=%0d st=%0d last=%0b",
                        rsp_data.channel_index, rsp_data.channel_value,
                        rsp_data.link_status, rsp_data.last);
         end else begin
            want = words_due.pop_front();
            if (rsp_data.channel_index !== want.channel_index ||
                rsp_data.channel_value !== want.channel_value ||
                rsp_data.link_status   !== want.link_status   ||
                rsp_data.last          !== want.last) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                           want.channel_index, want.channel_value, want.link_status,
                           want.last, rsp_data.channel_index, rsp_data.channel_value,
                           rsp_data.link_status, rsp_data.last);
            end
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_DISARM;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 22;
      recv_idle_pct = 85;
      foreach (PLAN[i]) begin
         case (PLAN[i].kind)
            ROW_BYTE: send_req(OP_BYTE, PLAN[i].arg_a[7:0], PLAN[i].typed, PLAN[i].no_sig);
            ROW_TICK: send_req(OP_TICK, 8'($urandom), PLAN[i].typed, PLAN[i].no_sig);
            ROW_CSR:  write_csr(PLAN[i].arg_a[CSR_IDX_W-1:0], PLAN[i].arg_b);
            default: begin
               fill_channels(PLAN[i].arg_a, PLAN[i].arg_b, 1'b0);
               send_frame(PLAN[i].kind == ROW_BAD_FRAME, PLAN[i].typed, 1'b0, FRAME_BYTES);
            end
         endcase
      end

      run_random(40);
      send_idle_pct = 85;
      recv_idle_pct = 22;
      run_random(40);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(40);

      req_valid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && words_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
